// File: rtl/core/blv_pkg.sv
// ----------------------------------------------------------------------------
// blv_pkg
// Shared types, constants and register codes of the battery level indicator.
// ----------------------------------------------------------------------------
package blv_pkg;

  // averaging window in ticks
  localparam int unsigned AVG_SAMPLES = 1000;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 26;
  localparam int COUNT_W  = 10;
  localparam int AVG_W    = 16;
  localparam int CFG_W    = 16;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // divide by AVG_SAMPLES as a multiply by a rounded-up reciprocal; exact for
  // any sum below 2**SUM_W since the rounding error stays under 2**DIV_SHIFT
  localparam int DIV_SHIFT = SUM_W + $clog2(AVG_SAMPLES);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
  localparam logic [RECIP_W-1:0] DIV_RECIP_V = RECIP_W'(DIV_RECIP);
  localparam logic [COUNT_W-1:0] AVG_COUNT   = COUNT_W'(AVG_SAMPLES);

  localparam logic [CFG_W-1:0] SETTLE_RESET = 16'd5000;
  localparam logic [CFG_W-1:0] BLINK_RESET  = 16'd500;

  typedef enum logic [1:0] {
    LVL_UNKNOWN  = 2'd0,
    LVL_UNDER75  = 2'd1,
    LVL_UNDER100 = 2'd2,
    LVL_FULL     = 2'd3
  } level_t;

  typedef enum logic [2:0] {
    REG_LEVEL_75_THRESHOLD = 3'd0,
    REG_CHARGE_OFFSET      = 3'd1,
    REG_LED_LOAD_OFFSET    = 3'd2,
    REG_AUDIO_LOAD_OFFSET  = 3'd3,
    REG_SETTLE_TICKS       = 3'd4,
    REG_BLINK_TICKS        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] level_75_threshold;
    logic [CFG_W-1:0] charge_offset;
    logic [CFG_W-1:0] led_load_offset;
    logic [CFG_W-1:0] audio_load_offset;
    logic [CFG_W-1:0] settle_ticks;
    logic [CFG_W-1:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_voltage;
    logic                supply_present;
    logic                charger_full;
    logic                led_load_on;
    logic                audio_load_on;
  } tick_t;

  typedef struct packed {
    logic             pin_led_75;
    logic             pin_led_red;
    logic             pin_led_green;
    logic [AVG_W-1:0] average_voltage;
    logic [1:0]       shown_level;
  } status_t;

  // item handed from the averaging stages to the indicator stage
  typedef struct packed {
    logic             charger_full;
    logic             period_end;
    logic [AVG_W-1:0] quotient;
  } avg_item_t;

  // stage advance strobes
  typedef struct packed {
    logic acc_en;
    logic mul_en;
  } pipe_ctl_t;

endpackage

// File: rtl/core/blv_avg.sv
// ----------------------------------------------------------------------------
// blv_avg
// Load correction, running sum over the averaging window and reciprocal divide.
// ----------------------------------------------------------------------------
module blv_avg (
  input  logic                clk,
  input  logic                rst,
  input  blv_pkg::cfg_t       cfg,
  input  blv_pkg::tick_t      tick,
  input  blv_pkg::pipe_ctl_t  ctl,
  output blv_pkg::avg_item_t  avg_item
);

  logic [blv_pkg::SUM_W-1:0]    sample_sum;
  logic [blv_pkg::COUNT_W-1:0]  sample_count;
  logic [blv_pkg::SUM_W-1:0]    sum_total;
  logic [blv_pkg::COUNT_W-1:0]  count_total;
  logic                         period_end;
  logic [blv_pkg::SAMPLE_W-1:0] corrected;
  logic [blv_pkg::SAMPLE_W+1:0] boosted;

  logic [blv_pkg::SUM_W-1:0]    s2_sum;
  logic                         s2_end;
  logic                         s2_charger;
  logic [blv_pkg::PROD_W-1:0]   product;
  blv_pkg::avg_item_t           s3_item;

  // load correction, saturated to the sample range
  always_comb begin
    boosted = {2'b00, tick.sample_voltage};
    if (tick.led_load_on) begin
      boosted = boosted + {2'b00, cfg.led_load_offset};
    end
    if (tick.audio_load_on) begin
      boosted = boosted + {2'b00, cfg.audio_load_offset};
    end
    if (tick.supply_present) begin
      corrected = (tick.sample_voltage > cfg.charge_offset) ?
                  tick.sample_voltage - cfg.charge_offset : '0;
    end else if (boosted[blv_pkg::SAMPLE_W+1:blv_pkg::SAMPLE_W] != 2'b00) begin
      corrected = '1;
    end else begin
      corrected = boosted[blv_pkg::SAMPLE_W-1:0];
    end
  end

  assign sum_total   = sample_sum + blv_pkg::SUM_W'(corrected);
  assign count_total = sample_count + blv_pkg::COUNT_W'(1);
  assign period_end  = (count_total >= blv_pkg::AVG_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (ctl.acc_en) begin
      sample_sum   <= period_end ? '0 : sum_total;
      sample_count <= period_end ? '0 : count_total;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      s2_sum     <= sum_total;
      s2_end     <= period_end;
      s2_charger <= tick.charger_full;
    end
  end

  assign product = {{blv_pkg::RECIP_W{1'b0}}, s2_sum} *
                   {{blv_pkg::SUM_W{1'b0}}, blv_pkg::DIV_RECIP_V};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      s3_item.charger_full <= s2_charger;
      s3_item.period_end   <= s2_end;
      s3_item.quotient     <= product[blv_pkg::DIV_SHIFT +: blv_pkg::AVG_W];
    end
  end

  assign avg_item = s3_item;

endmodule

// File: rtl/core/blv_ind.sv
// ----------------------------------------------------------------------------
// blv_ind
// Level choice, settle delay, blink timers and LED pin drive.
// ----------------------------------------------------------------------------
module blv_ind (
  input  logic                clk,
  input  logic                rst,
  input  blv_pkg::cfg_t       cfg,
  input  logic                en,
  input  blv_pkg::avg_item_t  avg_item,
  output blv_pkg::status_t    status
);

  logic [blv_pkg::AVG_W-1:0] averaged_voltage, averaged_voltage_next;
  blv_pkg::level_t           pending_level, pending_level_next;
  blv_pkg::level_t           displayed_level, displayed_level_next;
  blv_pkg::level_t           level;
  logic [blv_pkg::CFG_W-1:0] settle_timer, settle_timer_next;
  logic [blv_pkg::CFG_W-1:0] blink_timer_low, blink_timer_low_next;
  logic [blv_pkg::CFG_W-1:0] blink_timer_mid, blink_timer_mid_next;
  logic [blv_pkg::CFG_W-1:0] settle_now, low_now, mid_now;
  logic [2:0]                led_pins, led_pins_next;  // green, red, 75

  always_comb begin
    averaged_voltage_next = avg_item.period_end ? avg_item.quotient : averaged_voltage;

    if (avg_item.charger_full) begin
      level = blv_pkg::LVL_FULL;
    end else if (averaged_voltage_next < cfg.level_75_threshold) begin
      level = blv_pkg::LVL_UNDER75;
    end else begin
      level = blv_pkg::LVL_UNDER100;
    end

    pending_level_next   = pending_level;
    displayed_level_next = displayed_level;
    settle_now           = settle_timer;
    if (pending_level == blv_pkg::LVL_UNKNOWN) begin
      pending_level_next   = level;
      displayed_level_next = level;
    end else if (pending_level != level) begin
      pending_level_next = level;
      settle_now         = cfg.settle_ticks;
    end
    if (displayed_level_next != pending_level_next && settle_now == '0) begin
      displayed_level_next = pending_level_next;
    end

    low_now       = blink_timer_low;
    mid_now       = blink_timer_mid;
    led_pins_next = led_pins;
    unique case (displayed_level_next)
      blv_pkg::LVL_UNDER75: begin
        if (blink_timer_low == '0) begin
          low_now       = cfg.blink_ticks;
          led_pins_next = {2'b11, ~led_pins[0]};
        end
      end
      blv_pkg::LVL_UNDER100: begin
        if (blink_timer_mid == '0) begin
          mid_now       = cfg.blink_ticks;
          led_pins_next = {1'b1, ~led_pins[1], 1'b0};
        end
      end
      blv_pkg::LVL_FULL: begin
        led_pins_next = 3'b011;
      end
      default: begin
        led_pins_next = 3'b111;
      end
    endcase

    // timers count down after the led logic, holding at zero
    settle_timer_next    = (settle_now != '0) ? settle_now - blv_pkg::CFG_W'(1) : '0;
    blink_timer_low_next = (low_now != '0) ? low_now - blv_pkg::CFG_W'(1) : '0;
    blink_timer_mid_next = (mid_now != '0) ? mid_now - blv_pkg::CFG_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      averaged_voltage <= '0;
      pending_level    <= blv_pkg::LVL_UNKNOWN;
      displayed_level  <= blv_pkg::LVL_UNKNOWN;
      settle_timer     <= '0;
      blink_timer_low  <= '0;
      blink_timer_mid  <= '0;
      led_pins         <= '0;
    end else if (en) begin
      averaged_voltage <= averaged_voltage_next;
      pending_level    <= pending_level_next;
      displayed_level  <= displayed_level_next;
      settle_timer     <= settle_timer_next;
      blink_timer_low  <= blink_timer_low_next;
      blink_timer_mid  <= blink_timer_mid_next;
      led_pins         <= led_pins_next;
    end
  end

  assign status.pin_led_75      = led_pins[0];
  assign status.pin_led_red     = led_pins[1];
  assign status.pin_led_green   = led_pins[2];
  assign status.average_voltage = averaged_voltage;
  assign status.shown_level     = displayed_level;

endmodule

// File: rtl/core/battery_level_led_indicator_core.sv
// ----------------------------------------------------------------------------
// battery_level_led_indicator_core
// Averages load-corrected battery samples and drives three status LED pins.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                              one transfer
//  tick      in   tick_valid, tick_stall, tick_data     one 1 ms tick sample
//  status    out  status_valid, status_stall, status_data   one pin/level update
//  config    in   psel, penable, pwrite, paddr, pwdata, prdata, pready
//
//  pipeline: one transfer per cycle sustained while status_stall is low;
//  stages are input register, accumulate, reciprocal multiply and the
//  level/led register, which also serves as the status output register
//  reset: rst is synchronous; clears pipeline valids, sums, levels, timers,
//  pins and the config registers (settle 5000, blink 500)
//  stalls: each stage holds while the one after it is full and not moving,
//  so tick transfers continue until every stage is occupied
//
module battery_level_led_indicator_core (
  input  logic                         clk,
  input  logic                         rst,
  // tick channel
  input  logic                         tick_valid,
  output logic                         tick_stall,
  input  blv_pkg::tick_t               tick_data,
  // status channel
  output logic                         status_valid,
  input  logic                         status_stall,
  output blv_pkg::status_t             status_data,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [blv_pkg::PADDR_W-1:0]  paddr,
  input  logic [blv_pkg::PDATA_W-1:0]  pwdata,
  output logic [blv_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  blv_pkg::cfg_t      cfg;
  blv_pkg::reg_idx_t  reg_idx;
  logic               cfg_write;

  blv_pkg::tick_t     s1_tick;
  logic               s1_valid, s2_valid, s3_valid;
  logic               s1_free, s2_free, s3_free, out_free;
  logic               s1_adv, s2_adv, s3_adv;
  logic               tick_take;
  blv_pkg::pipe_ctl_t ctl;
  blv_pkg::avg_item_t avg_item;

  // ---------------------------------------------------------------- registers
  assign pready    = 1'b1;
  assign reg_idx   = blv_pkg::reg_idx_t'(paddr[blv_pkg::PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_75_threshold <= '0;
      cfg.charge_offset      <= '0;
      cfg.led_load_offset    <= '0;
      cfg.audio_load_offset  <= '0;
      cfg.settle_ticks       <= blv_pkg::SETTLE_RESET;
      cfg.blink_ticks        <= blv_pkg::BLINK_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        blv_pkg::REG_LEVEL_75_THRESHOLD: cfg.level_75_threshold <= pwdata[15:0];
        blv_pkg::REG_CHARGE_OFFSET:      cfg.charge_offset      <= pwdata[15:0];
        blv_pkg::REG_LED_LOAD_OFFSET:    cfg.led_load_offset    <= pwdata[15:0];
        blv_pkg::REG_AUDIO_LOAD_OFFSET:  cfg.audio_load_offset  <= pwdata[15:0];
        blv_pkg::REG_SETTLE_TICKS:       cfg.settle_ticks       <= pwdata[15:0];
        blv_pkg::REG_BLINK_TICKS:        cfg.blink_ticks        <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // read mux, unused addresses read as zero
  always_comb begin
    unique case (reg_idx)
      blv_pkg::REG_LEVEL_75_THRESHOLD: prdata = {16'd0, cfg.level_75_threshold};
      blv_pkg::REG_CHARGE_OFFSET:      prdata = {16'd0, cfg.charge_offset};
      blv_pkg::REG_LED_LOAD_OFFSET:    prdata = {16'd0, cfg.led_load_offset};
      blv_pkg::REG_AUDIO_LOAD_OFFSET:  prdata = {16'd0, cfg.audio_load_offset};
      blv_pkg::REG_SETTLE_TICKS:       prdata = {16'd0, cfg.settle_ticks};
      blv_pkg::REG_BLINK_TICKS:        prdata = {16'd0, cfg.blink_ticks};
      default:                         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- pipeline control
  // a stage can take a new item when empty or when its item moves on this cycle
  assign out_free = !status_valid || !status_stall;
  assign s3_adv   = s3_valid && out_free;
  assign s3_free  = !s3_valid || out_free;
  assign s2_adv   = s2_valid && s3_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s2_free;

  assign tick_stall = !s1_free;
  assign tick_take  = tick_valid && s1_free;

  assign ctl.acc_en = s1_adv;
  assign ctl.mul_en = s2_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      status_valid <= 1'b0;
    end else begin
      s1_valid     <= tick_take || (s1_valid && !s1_adv);
      s2_valid     <= s1_adv || (s2_valid && !s2_adv);
      s3_valid     <= s2_adv || (s3_valid && !s3_adv);
      status_valid <= s3_adv || (status_valid && status_stall);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (tick_take) begin
      s1_tick <= tick_data;
    end
  end

  // correction, accumulation and divide by the window length
  blv_avg u_avg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .tick     (s1_tick),
    .ctl      (ctl),
    .avg_item (avg_item)
  );

  // level selection and led drive; its state registers are the status payload
  blv_ind u_ind (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .en       (s3_adv),
    .avg_item (avg_item),
    .status   (status_data)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the battery level indicator core. Load-corrected
// samples, averaging, level settling and LED blinking are predicted per tick
// and every status transfer is compared against that prediction or a typed
// table value. A short directed table runs first, then randomized phases
// under changing settings, bursty ticks and patterned status back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import blv_pkg::*;

  // generous bound on the whole run, in clock cycles
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 7;
  localparam int DRAIN_CYCLES = 8;

  // flag nibble of a tick: {supply, charger, led, audio}
  localparam logic [3:0] F_NONE    = 4'b0000;
  localparam logic [3:0] F_SUPPLY  = 4'b1000;
  localparam logic [3:0] F_CHARGER = 4'b0100;
  localparam logic [3:0] F_LED     = 4'b0010;
  localparam logic [3:0] F_AUDIO   = 4'b0001;

  // status values that follow directly from the directed settings
  localparam status_t ST_MID_BLINK_ON = {1'b0, 1'b1, 1'b1, 16'd0, LVL_UNDER100};
  localparam status_t ST_FULL_NO_AVG  = {1'b1, 1'b1, 1'b0, 16'd0, LVL_FULL};

  typedef enum logic [2:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC,
    STALL_HOLD
  } stall_mode_t;

  // led pin image, all active low
  typedef struct packed {
    logic green;
    logic red;
    logic led75;
  } led_pins_t;

  typedef struct {
    int      phase;
    tick_t   tick;
    bit      typed;
    status_t want;
  } stim_row_t;

  // clock, reset and block inputs, all known from time zero
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 tick_valid   = 1'b0;
  tick_t                tick_data    = '0;
  logic                 status_stall = 1'b0;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [PADDR_W-1:0]   paddr        = '0;
  logic [PDATA_W-1:0]   pwdata       = '0;

  logic                 tick_stall;
  logic                 status_valid;
  status_t              status_data;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // shadow of the block: settings and indicator state
  cfg_t                 cfg_shadow;
  logic [SUM_W-1:0]     acc_sum       = '0;
  logic [COUNT_W-1:0]   acc_count     = '0;
  logic [AVG_W-1:0]     avg_volt      = '0;
  level_t               pend_lvl      = LVL_UNKNOWN;
  level_t               shown_lvl     = LVL_UNKNOWN;
  logic [CFG_W-1:0]     settle_cnt    = '0;
  logic [CFG_W-1:0]     blink_low_cnt = '0;
  logic [CFG_W-1:0]     blink_mid_cnt = '0;
  led_pins_t            led_pins      = '0;

  // expected status transfers, oldest first
  status_t              expected_status[$];
  stim_row_t            stim_rows[$];
  cfg_t                 phase_cfg[3];

  int                   fail_count  = 0;
  int                   cycle_count = 0;
  int                   burst_left  = 0;
  bit                   gaps_on     = 1'b1;

  // per-phase shape of the random ticks
  bit                   charger_hold = 1'b0;
  int unsigned          samp_lo      = 0;
  int unsigned          samp_hi      = 65535;
  int unsigned          supply_odds  = 3;

  stall_mode_t          stall_mode   = STALL_NONE;
  int                   stall_left   = 0;

  battery_level_led_indicator_core uut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick_data    (tick_data),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status_data  (status_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one tick of the indicator: correction, averaging, level, leds, timers
  task automatic predict_indicator(input tick_t t, output status_t s);
    logic [17:0] corr;
    level_t      lvl;
    // on supply only the charge offset applies, floored at zero
    if (t.supply_present) begin
      corr = (t.sample_voltage > cfg_shadow.charge_offset) ?
             18'(t.sample_voltage - cfg_shadow.charge_offset) : 18'd0;
    end else begin
      corr = 18'(t.sample_voltage);
      if (t.led_load_on) corr = corr + 18'(cfg_shadow.led_load_offset);
      if (t.audio_load_on) corr = corr + 18'(cfg_shadow.audio_load_offset);
      if (corr > 18'h0FFFF) corr = 18'h0FFFF;
    end

    acc_count = acc_count + COUNT_W'(1);
    acc_sum   = acc_sum + SUM_W'(corr);
    if (32'(acc_count) >= AVG_SAMPLES) begin
      avg_volt  = AVG_W'(32'(acc_sum) / 32'(acc_count));
      acc_count = '0;
      acc_sum   = '0;
    end

    // charger wins, else the threshold splits the two lower levels
    if (t.charger_full) lvl = LVL_FULL;
    else if (avg_volt < cfg_shadow.level_75_threshold) lvl = LVL_UNDER75;
    else lvl = LVL_UNDER100;

    // the very first level is shown at once, later ones wait out the settle time
    if (pend_lvl == LVL_UNKNOWN) begin
      pend_lvl  = lvl;
      shown_lvl = lvl;
    end else if (pend_lvl != lvl) begin
      pend_lvl   = lvl;
      settle_cnt = cfg_shadow.settle_ticks;
    end
    if (shown_lvl != pend_lvl && settle_cnt == '0) shown_lvl = pend_lvl;

    case (shown_lvl)
      LVL_UNDER75: begin
        if (blink_low_cnt == '0) begin
          blink_low_cnt = cfg_shadow.blink_ticks;
          led_pins      = '{green: 1'b1, red: 1'b1, led75: ~led_pins.led75};
        end
      end
      LVL_UNDER100: begin
        if (blink_mid_cnt == '0) begin
          blink_mid_cnt = cfg_shadow.blink_ticks;
          led_pins      = '{green: 1'b1, red: ~led_pins.red, led75: 1'b0};
        end
      end
      LVL_FULL: begin
        led_pins = '{green: 1'b0, red: 1'b1, led75: 1'b1};
      end
      default: begin
        led_pins = '{green: 1'b1, red: 1'b1, led75: 1'b1};
      end
    endcase

    // timers run down after the led logic and stop at zero
    if (settle_cnt != '0) settle_cnt = settle_cnt - CFG_W'(1);
    if (blink_low_cnt != '0) blink_low_cnt = blink_low_cnt - CFG_W'(1);
    if (blink_mid_cnt != '0) blink_mid_cnt = blink_mid_cnt - CFG_W'(1);

    s.pin_led_75      = led_pins.led75;
    s.pin_led_red     = led_pins.red;
    s.pin_led_green   = led_pins.green;
    s.average_voltage = avg_volt;
    s.shown_level     = shown_lvl;
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LEVEL_75_THRESHOLD: cfg_shadow.level_75_threshold = val;
      REG_CHARGE_OFFSET:      cfg_shadow.charge_offset      = val;
      REG_LED_LOAD_OFFSET:    cfg_shadow.led_load_offset    = val;
      REG_AUDIO_LOAD_OFFSET:  cfg_shadow.audio_load_offset  = val;
      REG_SETTLE_TICKS:       cfg_shadow.settle_ticks       = val;
      REG_BLINK_TICKS:        cfg_shadow.blink_ticks        = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_LEVEL_75_THRESHOLD, c.level_75_threshold);
    write_reg(REG_CHARGE_OFFSET, c.charge_offset);
    write_reg(REG_LED_LOAD_OFFSET, c.led_load_offset);
    write_reg(REG_AUDIO_LOAD_OFFSET, c.audio_load_offset);
    write_reg(REG_SETTLE_TICKS, c.settle_ticks);
    write_reg(REG_BLINK_TICKS, c.blink_ticks);
  endtask

  // one tick transfer; bursts of random length separated by random gaps
  task automatic send_tick(input tick_t t, input bit typed, input status_t want);
    status_t s;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 3);
        8:          gap = $urandom_range(4, 12);
        default:    gap = $urandom_range(20, 40);
      endcase
      if (!gaps_on) gap = 0;
      if (gap > 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick_valid <= 1'b1;
    tick_data  <= t;
    do @(posedge clk); while (tick_stall !== 1'b0);
    predict_indicator(t, s);
    expected_status.push_back(typed ? want : s);
  endtask

  // stop sending and wait until every status transfer has come back
  task automatic finish_stream();
    tick_valid <= 1'b0;
    burst_left = 0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input int ph, input logic [15:0] v, input logic [3:0] flags,
                         input bit typed, input status_t want);
    stim_row_t r;
    r.phase = ph;
    r.tick  = {v, flags};
    r.typed = typed;
    r.want  = want;
    stim_rows.push_back(r);
  endtask

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic cfg_t pick_config();
    cfg_t c;
    // threshold at, above or away from the average, so both low levels show up
    case ($urandom_range(0, 4))
      0:       c.level_75_threshold = 16'd0;
      1:       c.level_75_threshold = 16'hFFFF;
      2:       c.level_75_threshold = avg_volt;
      3:       c.level_75_threshold = (avg_volt == 16'hFFFF) ? avg_volt :
                                      avg_volt + AVG_W'(1);
      default: c.level_75_threshold = 16'($urandom_range(0, 65535));
    endcase
    c.charge_offset     = pick_offset();
    c.led_load_offset   = pick_offset();
    c.audio_load_offset = pick_offset();
    case ($urandom_range(0, 5))
      0:       c.settle_ticks = 16'd0;
      1:       c.settle_ticks = 16'd1;
      5:       c.settle_ticks = 16'($urandom_range(0, 65535));
      default: c.settle_ticks = 16'($urandom_range(2, 40));
    endcase
    case ($urandom_range(0, 4))
      0:       c.blink_ticks = 16'd0;
      1:       c.blink_ticks = 16'd1;
      4:       c.blink_ticks = 16'($urandom_range(16, 400));
      default: c.blink_ticks = 16'($urandom_range(2, 15));
    endcase
    return c;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    // charger state is sticky so levels last long enough to settle and blink
    if ($urandom_range(0, 49) == 0) charger_hold = ~charger_hold;
    case ($urandom_range(0, 9))
      0:       t.sample_voltage = 16'd0;
      1:       t.sample_voltage = 16'hFFFF;
      default: t.sample_voltage = 16'($urandom_range(samp_lo, samp_hi));
    endcase
    t.supply_present = ($urandom_range(0, 9) < supply_odds);
    // short charger glitches restart the settle timer
    t.charger_full   = ($urandom_range(0, 39) == 0) ? ~charger_hold : charger_hold;
    t.led_load_on    = 1'($urandom_range(0, 1));
    t.audio_load_on  = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // status side back-pressure; the mode is redrawn whenever stall_left runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 4));
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     status_stall <= 1'b0;
      STALL_LIGHT:    status_stall <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY:    status_stall <= ($urandom_range(0, 9) < 8);
      STALL_PERIODIC: status_stall <= ((stall_left % 7) < 3);
      default:        status_stall <= 1'b1;
    endcase
  end

  // status monitor: each transfer against the oldest expectation
  always @(posedge clk) begin
    status_t want;
    if (!rst && status_valid === 1'b1 && status_stall === 1'b0) begin
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("status transfer with nothing expected: %h", status_data);
      end else begin
        want = expected_status.pop_front();
        if (status_data.pin_led_75 !== want.pin_led_75)
          note_mismatch("pin_led_75", 16'(want.pin_led_75), 16'(status_data.pin_led_75));
        if (status_data.pin_led_red !== want.pin_led_red)
          note_mismatch("pin_led_red", 16'(want.pin_led_red), 16'(status_data.pin_led_red));
        if (status_data.pin_led_green !== want.pin_led_green)
          note_mismatch("pin_led_green", 16'(want.pin_led_green),
                        16'(status_data.pin_led_green));
        if (status_data.average_voltage !== want.average_voltage)
          note_mismatch("average_voltage", want.average_voltage, status_data.average_voltage);
        if (status_data.shown_level !== want.shown_level)
          note_mismatch("shown_level", 16'(want.shown_level), 16'(status_data.shown_level));
      end
    end
  end

  initial begin
    int cur_phase;
    int n_items;
    // settings after reset
    cfg_shadow = '0;
    cfg_shadow.settle_ticks = SETTLE_RESET;
    cfg_shadow.blink_ticks  = BLINK_RESET;

    // directed settings, field order: threshold, charge, led, audio, settle, blink
    phase_cfg[0] = cfg_shadow;
    phase_cfg[1] = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    phase_cfg[2] = {16'd0, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF};

    // reset settings: first level shown at once, charger change held by settle
    add_row(0, 16'd0,    F_NONE,    1'b1, ST_MID_BLINK_ON);
    add_row(0, 16'hFFFF, F_NONE,    1'b1, ST_MID_BLINK_ON);
    add_row(0, 16'hFFFF, F_CHARGER, 1'b1, ST_MID_BLINK_ON);
    add_row(0, 16'd0,    F_SUPPLY | F_CHARGER | F_LED | F_AUDIO, 1'b1, ST_MID_BLINK_ON);
    add_row(0, 16'd1,    F_NONE,    1'b0, '0);
    // extreme offsets, no settle delay, blink on every tick
    add_row(1, 16'hFFFF, F_LED | F_AUDIO, 1'b0, '0);
    add_row(1, 16'd0,    F_SUPPLY,        1'b0, '0);
    add_row(1, 16'hFFFF, F_SUPPLY,        1'b0, '0);
    add_row(1, 16'd12345, F_NONE,         1'b0, '0);
    add_row(1, 16'd0,    F_CHARGER,       1'b1, ST_FULL_NO_AVG);
    add_row(1, 16'd0,    F_SUPPLY | F_CHARGER | F_LED | F_AUDIO, 1'b1, ST_FULL_NO_AVG);
    add_row(1, 16'd40000, F_LED,          1'b0, '0);
    add_row(1, 16'd1,    F_AUDIO,         1'b0, '0);
    add_row(1, 16'hFFFE, F_LED | F_AUDIO, 1'b0, '0);
    add_row(1, 16'h8000, F_SUPPLY | F_LED | F_AUDIO, 1'b0, '0);
    // longest settle and blink, zero threshold
    add_row(2, 16'd0,    F_SUPPLY,         1'b0, '0);
    add_row(2, 16'd1,    F_SUPPLY | F_LED, 1'b0, '0);
    add_row(2, 16'hFFFF, F_LED | F_AUDIO,  1'b0, '0);
    add_row(2, 16'd200,  F_CHARGER,        1'b0, '0);
    add_row(2, 16'hFFFF, F_NONE,           1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    cur_phase = 0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].phase != cur_phase) begin
        finish_stream();
        cur_phase = stim_rows[i].phase;
        apply_config(phase_cfg[cur_phase]);
      end
      send_tick(stim_rows[i].tick, stim_rows[i].typed, stim_rows[i].want);
    end
    finish_stream();

    // random phases, each with fresh settings and traffic shape
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apply_config(pick_config());
      samp_lo      = $urandom_range(0, 65535);
      samp_hi      = $urandom_range(samp_lo, 65535);
      supply_odds  = $urandom_range(0, 10);
      charger_hold = 1'($urandom_range(0, 1));
      gaps_on      = ($urandom_range(0, 3) != 0);
      n_items      = $urandom_range(220, 280);
      repeat (n_items) send_tick(random_tick(), 1'b0, '0);
      finish_stream();
    end

    // let any stray transfer show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_status.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
